// ===== rtl/rarmt_pkg.sv =====
package rarmt_pkg;

  localparam int unsigned DefSize  = 1024;
  localparam int unsigned ValW     = 48;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned LoW      = 10;
  localparam int unsigned HiW      = 11;
  localparam int unsigned AddW     = 32;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MIN = 1'b1;

  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    val_t mn;
    val_t pend;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_LEAF,
    ST_PD_NODE,
    ST_PD_L,
    ST_PD_R,
    ST_RET,
    ST_UP_A,
    ST_UP_B,
    ST_DONE
  } state_t;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) begin
      sat_add = s[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      sat_add = s[ValW-1:0];
    end
  endfunction

  function automatic node_t mark(input node_t d, input val_t v);
    node_t r;
    r.mn   = sat_add(d.mn, v);
    r.pend = sat_add(d.pend, v);
    mark   = r;
  endfunction

  function automatic val_t vmin(input val_t a, input val_t b);
    vmin = (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/rarmt_node_ram.sv =====
module rarmt_node_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  rarmt_pkg::node_t      wdata,
  input  logic [AW-1:0]         raddr,
  output rarmt_pkg::node_t      rdata
);
  import rarmt_pkg::*;

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/range_add_range_min_tree_core.sv =====
// range-add / range-minimum store over a signed array of up to SIZE elements, kept as a
// segment tree with pending-add marks in one node ram of 4*SIZE words (each word holds a
// node minimum and a pending add, both 48-bit saturating). an add command adds in_add_value
// over [in_range_lo, in_range_hi); a min command returns one word with the minimum over the
// range, or 0 if the range is empty after clipping to the element count. a command walks the
// tree depth-first with a small frame stack; the single-port-read node ram sets the pace:
// a fully covered node is read and, for an add, rewritten; a partly covered node going down
// has the node and both children read and rewritten, and coming back it rereads both children
// and rewrites the node for an add, or folds the left answer in for a query. an add with an
// empty range is dropped in idle, a query with an empty range goes straight to the output.
// one command is worked at a time; a finished result waits in the output register while the
// next command is taken. after reset and after every cfg_we write the ram is cleared word by
// word, during which in_stall is high
module range_add_range_min_tree_core #(
  parameter int unsigned SIZE = rarmt_pkg::DefSize
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rarmt_pkg::CfgW-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [rarmt_pkg::LoW-1:0]         in_range_lo,
  input  logic [rarmt_pkg::HiW-1:0]         in_range_hi,
  input  logic signed [rarmt_pkg::AddW-1:0] in_add_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rarmt_pkg::ValW-1:0] out_min_value
);
  import rarmt_pkg::*;

  localparam int unsigned XW    = $clog2(SIZE);
  localparam int unsigned AW    = (XW + 1 > 12) ? XW + 1 : 12;   // index arithmetic width
  localparam int unsigned NDEP  = 4 * SIZE;
  localparam int unsigned NW    = $clog2(NDEP);
  localparam int unsigned SDEP  = XW + 2;                       // frame stack depth
  localparam int unsigned TPW   = $clog2(SDEP);

  // control
  state_t state_r, state_nxt;
  logic [NW-1:0]  clr_r;
  logic [AW-1:0]  count_r;
  logic [TPW-1:0] tp_r;

  // command
  logic           cmd_r;
  logic [AW-1:0]  qlo_r, qhi_r;
  val_t           v_r;
  val_t           p_r;          // pending add being handed down
  val_t           a_r;          // left child minimum during recompute
  logic           ret_f_r;
  val_t           ret_v_r;
  val_t           res_r;
  logic           out_valid_r;
  val_t           out_val_r;

  // frame stack, only the top frame, its parent and the next free frame are touched
  logic [NW-1:0]  stk_idx   [SDEP];
  logic [AW-1:0]  stk_lo    [SDEP];
  logic [AW-1:0]  stk_hi    [SDEP];
  logic           stk_ph    [SDEP];
  logic           stk_fa    [SDEP];
  val_t           stk_a     [SDEP];

  // ram port
  logic           m_we;
  logic [NW-1:0]  m_waddr, m_raddr;
  node_t          m_wdata, m_rdata;

  rarmt_node_ram #(.DEPTH(NDEP), .AW(NW)) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // top frame and its parent
  logic [TPW-1:0] tpp;
  logic [NW-1:0]  f_idx, f_lc, f_rc, p_idx, p_lc, p_rc;
  logic [AW-1:0]  f_lo, f_hi, f_m, p_lo, p_hi, p_m;
  logic           f_disj, f_cov, p_ph, p_fa;
  val_t           p_a;

  assign tpp    = tp_r - TPW'(1);
  assign f_idx  = stk_idx[tp_r];
  assign f_lo   = stk_lo[tp_r];
  assign f_hi   = stk_hi[tp_r];
  assign f_lc   = {f_idx[NW-2:0], 1'b0};
  assign f_rc   = {f_idx[NW-2:0], 1'b1};
  assign f_m    = (f_lo + f_hi) >> 1;
  assign f_disj = (f_lo > qhi_r) || (f_hi < qlo_r);
  assign f_cov  = (qlo_r <= f_lo) && (f_hi <= qhi_r);
  assign p_idx  = stk_idx[tpp];
  assign p_lo   = stk_lo[tpp];
  assign p_hi   = stk_hi[tpp];
  assign p_ph   = stk_ph[tpp];
  assign p_fa   = stk_fa[tpp];
  assign p_a    = stk_a[tpp];
  assign p_lc   = {p_idx[NW-2:0], 1'b0};
  assign p_rc   = {p_idx[NW-2:0], 1'b1};
  assign p_m    = (p_lo + p_hi) >> 1;

  // input clipping
  logic [AW-1:0] in_lo_w, in_hi_w, in_hic;
  logic          in_empty, in_acc;
  assign in_lo_w  = AW'(in_range_lo);
  assign in_hi_w  = AW'(in_range_hi);
  assign in_hic   = (in_hi_w > count_r) ? count_r : in_hi_w;
  assign in_empty = in_lo_w >= in_hic;
  assign in_acc   = in_valid && !in_stall;

  logic [AW-1:0] cfg_clip;
  always_comb begin
    cfg_clip = AW'(cfg_wdata);
    if (cfg_wdata == '0) begin
      cfg_clip = AW'(1);
    end else if (32'(cfg_wdata) > 32'(SIZE)) begin
      cfg_clip = AW'(SIZE);
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_r == NW'(NDEP - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_empty) state_nxt = ST_VISIT;
          else if (in_cmd == CMD_MIN) state_nxt = ST_DONE;
        end
      end
      ST_VISIT: begin
        if (f_disj) state_nxt = ST_RET;
        else if (f_cov) state_nxt = ST_LEAF;
        else state_nxt = ST_PD_NODE;
      end
      ST_LEAF:    state_nxt = ST_RET;
      ST_PD_NODE: state_nxt = ST_PD_L;
      ST_PD_L:    state_nxt = ST_PD_R;
      ST_PD_R:    state_nxt = ST_VISIT;
      ST_RET: begin
        if (tp_r == '0) begin
          state_nxt = (cmd_r == CMD_MIN) ? ST_DONE : ST_IDLE;
        end else if (!p_ph) begin
          state_nxt = ST_VISIT;
        end else if (cmd_r == CMD_ADD) begin
          state_nxt = ST_UP_A;
        end
      end
      ST_UP_A:    state_nxt = ST_UP_B;
      ST_UP_B:    state_nxt = ST_RET;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  // ram port and handshake outputs
  always_comb begin
    m_we    = 1'b0;
    m_waddr = f_idx;
    m_wdata = m_rdata;
    m_raddr = f_idx;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
      end
      ST_LEAF: begin
        m_we    = (cmd_r == CMD_ADD);
        m_wdata = mark(m_rdata, v_r);
      end
      ST_PD_NODE: begin
        m_we         = 1'b1;
        m_wdata.mn   = m_rdata.mn;
        m_wdata.pend = '0;
        m_raddr      = f_lc;
      end
      ST_PD_L: begin
        m_we    = 1'b1;
        m_waddr = f_lc;
        m_wdata = mark(m_rdata, p_r);
        m_raddr = f_rc;
      end
      ST_PD_R: begin
        m_we    = 1'b1;
        m_waddr = f_rc;
        m_wdata = mark(m_rdata, p_r);
      end
      ST_RET:   m_raddr = p_lc;
      ST_UP_A:  m_raddr = f_rc;
      ST_UP_B: begin
        m_we         = 1'b1;
        m_wdata.mn   = vmin(a_r, m_rdata.mn);
        m_wdata.pend = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_val_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= AW'(SIZE);
      tp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        count_r <= cfg_clip;
        clr_r   <= '0;
      end else if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + NW'(1);
      end
      if (state_r == ST_IDLE && in_acc) tp_r <= '0;
      if (state_r == ST_PD_R) tp_r <= tp_r + TPW'(1);
      if (state_r == ST_RET && tp_r != '0 && p_ph) tp_r <= tpp;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) out_val_r <= res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_r      <= in_cmd;
          qlo_r      <= in_lo_w;
          qhi_r      <= in_hic - AW'(1);
          v_r        <= {{(ValW-AddW){in_add_value[AddW-1]}}, in_add_value};
          res_r      <= '0;
          stk_idx[0] <= NW'(1);
          stk_lo[0]  <= '0;
          stk_hi[0]  <= count_r - AW'(1);
          stk_ph[0]  <= 1'b0;
        end
      end
      ST_VISIT: if (f_disj) ret_f_r <= 1'b0;
      ST_LEAF: begin
        ret_f_r <= 1'b1;
        ret_v_r <= m_rdata.mn;
      end
      ST_PD_NODE: p_r <= m_rdata.pend;
      ST_PD_R: begin
        stk_idx[tp_r + TPW'(1)] <= f_lc;
        stk_lo[tp_r + TPW'(1)]  <= f_lo;
        stk_hi[tp_r + TPW'(1)]  <= f_m;
        stk_ph[tp_r + TPW'(1)]  <= 1'b0;
      end
      ST_RET: begin
        if (tp_r == '0) begin
          res_r <= ret_f_r ? ret_v_r : '0;
        end else if (!p_ph) begin
          // left side done, keep its answer and go right
          stk_ph[tpp] <= 1'b1;
          stk_fa[tpp] <= ret_f_r;
          stk_a[tpp]  <= ret_v_r;
          stk_idx[tp_r] <= p_rc;
          stk_lo[tp_r]  <= p_m + AW'(1);
          stk_hi[tp_r]  <= p_hi;
          stk_ph[tp_r]  <= 1'b0;
        end else if (cmd_r == CMD_MIN) begin
          ret_f_r <= p_fa || ret_f_r;
          if (p_fa && ret_f_r) ret_v_r <= vmin(p_a, ret_v_r);
          else if (p_fa) ret_v_r <= p_a;
        end
      end
      ST_UP_A: a_r <= m_rdata.mn;
      ST_UP_B: ret_f_r <= 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/sv/tb_range_add_range_min_tree_core.sv =====
module tb_range_add_range_min_tree_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rarmt_pkg::*;

  localparam int unsigned NodeSlots = 4 * DefSize;
  localparam int unsigned WdogLimit = 20000;
  localparam int unsigned DrainWait = 200;
  localparam val_t        ValMax    = {1'b0, {(ValW-1){1'b1}}};
  localparam val_t        ValMin    = {1'b1, {(ValW-1){1'b0}}};

  // one row of the directed table; exp_min only counts where fixed is set
  typedef struct {
    logic             cmd;
    int unsigned      lo;
    int unsigned      hi;
    int               add;
    bit               fixed;
    longint           exp_min;
  } cmd_row_t;

  // a node waiting in the walk; back marks the recombine step on the way up
  typedef struct {
    int unsigned idx;
    int unsigned a;
    int unsigned b;
    bit          back;
  } node_frame_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgW-1:0]          cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_cmd;
  logic [LoW-1:0]           in_range_lo;
  logic [HiW-1:0]           in_range_hi;
  logic signed [AddW-1:0]   in_add_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ValW-1:0]   out_min_value;

  // shadow of the block's tree and its element count
  val_t        tree_min  [NodeSlots];
  val_t        tree_pend [NodeSlots];
  int unsigned elem_count;

  val_t        min_due[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          hold_req;

  range_add_range_min_tree_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_range_lo   (in_range_lo),
    .in_range_hi   (in_range_hi),
    .in_add_value  (in_add_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_min_value (out_min_value)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // 48-bit add clamped to the signed range
  function automatic val_t clamp_add(input val_t x, input val_t y);
    logic signed [ValW:0] s;
    s = {x[ValW-1], x} + {y[ValW-1], y};
    if (s > $signed({1'b0, ValMax})) return ValMax;
    if (s < $signed({1'b1, ValMin})) return ValMin;
    return s[ValW-1:0];
  endfunction

  function automatic void tag_node(input int unsigned idx, input val_t v);
    if (idx >= NodeSlots) return;
    tree_min[idx]  = clamp_add(tree_min[idx], v);
    tree_pend[idx] = clamp_add(tree_pend[idx], v);
  endfunction

  // move a node's pending add into both children
  function automatic void push_pending(input int unsigned idx);
    if (idx >= NodeSlots) return;
    tag_node(2 * idx, tree_pend[idx]);
    tag_node(2 * idx + 1, tree_pend[idx]);
    tree_pend[idx] = '0;
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < NodeSlots; i++) begin
      tree_min[i]  = '0;
      tree_pend[i] = '0;
    end
  endfunction

  // walks the tree depth-first with an explicit stack; an add marks covered
  // nodes and recombines on the way up, a query folds covered node minima
  function automatic val_t range_walk(input logic cmd, input int unsigned qlo,
                                      input int unsigned qhi, input val_t v);
    node_frame_t stack[$];
    node_frame_t f;
    int unsigned m;
    val_t        best;
    bit          found;
    best  = '0;
    found = 1'b0;
    stack.push_back('{idx: 1, a: 0, b: elem_count - 1, back: 1'b0});
    while (stack.size() > 0) begin
      f = stack.pop_back();
      if (f.back) begin
        if (2 * f.idx + 1 < NodeSlots)
          tree_min[f.idx] = (tree_min[2*f.idx] < tree_min[2*f.idx+1]) ?
                            tree_min[2*f.idx] : tree_min[2*f.idx+1];
        continue;
      end
      if (f.idx >= NodeSlots || f.a > qhi || f.b < qlo) continue;
      if (qlo <= f.a && f.b <= qhi) begin
        if (cmd == CMD_MIN) begin
          if (!found || tree_min[f.idx] < best) best = tree_min[f.idx];
          found = 1'b1;
        end else begin
          tag_node(f.idx, v);
        end
        continue;
      end
      push_pending(f.idx);
      m = (f.a + f.b) >> 1;
      if (cmd == CMD_ADD) stack.push_back('{idx: f.idx, a: f.a, b: f.b, back: 1'b1});
      stack.push_back('{idx: 2 * f.idx + 1, a: m + 1, b: f.b, back: 1'b0});
      stack.push_back('{idx: 2 * f.idx, a: f.a, b: m, back: 1'b0});
    end
    return found ? best : '0;
  endfunction

  // ---------------------------------------------------------------- driving

  // called just after a rising edge; returns just after the accepting edge
  task automatic issue(input logic cmd, input int unsigned lo, input int unsigned hi,
                       input int add, input int unsigned gap,
                       input bit fixed, input longint exp_min);
    int unsigned chi;
    val_t        got;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_range_lo  <= lo[LoW-1:0];
    in_range_hi  <= hi[HiW-1:0];
    in_add_value <= add;
    do @(posedge clk); while (in_stall);
    // the word went in at this edge: update the shadow tree
    chi = (hi > elem_count) ? elem_count : hi;
    got = '0;
    if (lo < chi) got = range_walk(cmd, lo, chi - 1, val_t'(add));
    if (cmd == CMD_MIN) min_due.push_back(fixed ? val_t'(exp_min) : got);
  endtask

  // element count write while the block is idle; also clears the tree
  task automatic set_count(input int unsigned value);
    in_valid <= 1'b0;
    wait (min_due.size() == 0);
    // an add may still be in flight
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CfgW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    elem_count = (value == 0) ? 1 : (value > DefSize) ? DefSize : value;
    clear_tree();
  endtask

  task automatic random_word(input int unsigned gap);
    int unsigned lo;
    int unsigned hi;
    int          add;
    logic        cmd;
    cmd = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 7) begin
      lo = $urandom_range(0, elem_count - 1);
      hi = $urandom_range(lo + 1, elem_count);
    end else begin
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 2047);
    end
    case ($urandom_range(0, 3))
      0: add = int'($urandom_range(0, 100)) - 50;
      1: add = $urandom;
      2: add = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: add = int'($urandom_range(0, 2000000)) - 1000000;
    endcase
    issue(cmd, lo, hi, add, gap, 1'b0, 0);
  endtask

  // ---------------------------------------------------------------- receiver

  // stalls at random before each word, or one long hold when asked
  initial begin
    int unsigned n;
    out_stall = 1'b1;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n        = 400;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (min_due.size() == 0) begin
        $display("%0t unexpected min word: expected none, got %0d", $time, out_min_value);
        mismatches++;
      end else begin
        if (out_min_value !== min_due[0]) begin
          $display("%0t min_value mismatch: expected %0d, got %0d",
                   $time, min_due[0], out_min_value);
          mismatches++;
        end
        void'(min_due.pop_front());
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WdogLimit) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  cmd_row_t directed[] = '{
    '{CMD_MIN, 0,    1024, 0,           1'b1, 0},
    '{CMD_MIN, 5,    5,    0,           1'b1, 0},           // empty range
    '{CMD_MIN, 1023, 2047, 0,           1'b1, 0},           // end clipped
    '{CMD_ADD, 0,    1024, 32'h7fffffff, 1'b0, 0},
    '{CMD_MIN, 0,    1024, 0,           1'b1, 2147483647},
    '{CMD_ADD, 5,    6,    32'h80000000, 1'b0, 0},
    '{CMD_MIN, 0,    1024, 0,           1'b1, -1},
    '{CMD_MIN, 6,    1024, 0,           1'b1, 2147483647},
    '{CMD_ADD, 1000, 2047, 32'h80000000, 1'b0, 0},           // clipped add
    '{CMD_MIN, 1000, 1024, 0,           1'b1, -1},
    '{CMD_MIN, 999,  1000, 0,           1'b1, 2147483647},
    '{CMD_ADD, 10,   3,    123,         1'b0, 0},           // empty add
    '{CMD_MIN, 0,    1023, 0,           1'b0, 0},
    '{CMD_ADD, 300,  701,  5,           1'b0, 0},
    '{CMD_MIN, 299,  702,  0,           1'b0, 0},
    '{CMD_MIN, 1023, 1024, 0,           1'b1, -1},
    '{CMD_ADD, 0,    1,    0,           1'b0, 0},
    '{CMD_MIN, 0,    1,    0,           1'b1, 2147483647},
    '{CMD_ADD, 512,  513,  -7,          1'b0, 0},
    '{CMD_MIN, 511,  514,  0,           1'b0, 0},
    '{CMD_MIN, 0,    0,    0,           1'b1, 0}
  };

  // element counts of the random phases, extremes and out of range among them
  int unsigned phase_counts[] = '{1024, 2, 37, 2047, 700, 0, 513, 1024};

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_cmd       = CMD_ADD;
    in_range_lo  = '0;
    in_range_hi  = '0;
    in_add_value = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    hold_req     = 1'b0;
    elem_count   = DefSize;
    clear_tree();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, straight after reset
    foreach (directed[i])
      issue(directed[i].cmd, directed[i].lo, directed[i].hi, directed[i].add,
            $urandom_range(0, 3), directed[i].fixed, directed[i].exp_min);

    // random phases
    foreach (phase_counts[p]) begin
      set_count(phase_counts[p]);
      for (int i = 0; i < 240; i++) begin
        // a run of back-to-back words every so often
        random_word((i % 60 < 15) ? 0 : $urandom_range(0, 3));
        if (p == 0 && i == 40) hold_req = 1'b1;   // receiver holds, block backs up
        if (p == 4 && i == 120) begin
          in_valid <= 1'b0;
          wait (min_due.size() == 0);              // sender waits for a full drain
          @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    wait (min_due.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
